FILE: rtl/sse_pkg.sv
// shared types, constants and helpers of the server-sent-events parser
`timescale 1ns / 1ps
package sse_pkg;

    localparam int LENGTH_BITS = 16;
    localparam logic [15:0] SIZE_LIMIT_RESET = 16'd4096;
    localparam int RQ_DEPTH = 4;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_COUNT   = 2'd3;

    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic        is_done_marker;
        logic [15:0] pending_count;
        logic        last_of_run;
    } t_res;

    // "data:" prefix
    function automatic logic [7:0] f_data_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h64;
            3'd1:    c = 8'h61;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h3a;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "[DONE]" marker
    function automatic logic [7:0] f_done_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h5b;
            3'd1:    c = 8'h44;
            3'd2:    c = 8'h4f;
            3'd3:    c = 8'h4e;
            3'd4:    c = 8'h45;
            3'd5:    c = 8'h5d;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/sse_in_if.sv
// input channel: opcode and stream byte with valid/ready
`timescale 1ns / 1ps
interface sse_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] in_byte;

    modport source (output valid, output opcode, output in_byte, input ready);
    modport sink   (input valid, input opcode, input in_byte, output ready);
endinterface

FILE: rtl/sse_out_if.sv
// output channel: parser results with valid/ready
`timescale 1ns / 1ps
interface sse_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        is_done_marker;
    logic [15:0] pending_count;
    logic        last_of_run;

    modport source (output valid, output kind, output payload_byte, output is_done_marker,
                    output pending_count, output last_of_run, input ready);
    modport sink   (input valid, input kind, input payload_byte, input is_done_marker,
                    input pending_count, input last_of_run, output ready);
endinterface

FILE: rtl/sse_core.sv
// parser state, size limit register and per-word result logic
`timescale 1ns / 1ps
module sse_core #(
    parameter int LENGTH_BITS = sse_pkg::LENGTH_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata,
    input  logic          i_accept,
    input  logic [1:0]    i_opcode,
    input  logic [7:0]    i_in_byte,
    output logic [1:0]    o_push_cnt,
    output sse_pkg::t_res o_res0,
    output sse_pkg::t_res o_res1
);

    localparam int CW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
    localparam logic [CW-1:0] CAP = CW'((64'd1 << LENGTH_BITS) - 64'd1);

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_PREFIX = 2'd1,
        PH_VALUE  = 2'd2,
        PH_IGNORE = 2'd3
    } t_phase;

    typedef struct packed {
        logic                   has_data;
        logic [LENGTH_BITS-1:0] len;
        logic [2:0]             match_pos;
        logic                   mismatch;
    } t_ev;

    typedef struct packed {
        t_ev           ev;
        sse_pkg::t_res res;
        logic          ok;
    } t_emit;

    logic [15:0]            r_limit;
    t_phase                 r_phase, n_phase;
    logic [2:0]             r_pos, n_pos;
    logic                   r_cr, n_cr;
    logic                   r_first, n_first;
    t_ev                    r_ev, n_ev;
    logic [LENGTH_BITS-1:0] r_line_len, n_line_len;

    logic [CW-1:0] lim;
    logic          line_full;
    t_emit         e1, e2;
    logic [1:0]    cnt;
    sse_pkg::t_res res0, res1;
    logic          go_on;

    function automatic t_emit f_emit(input t_ev ev, input logic [7:0] b,
                                     input logic [CW-1:0] lm);
        t_emit e;
        e = '0;
        if (CW'(ev.len) >= lm) begin
            e.res.kind = sse_pkg::KIND_ERROR;
            e.ev       = '0;
            e.ok       = 1'b0;
        end else begin
            e.ev             = ev;
            e.res.kind       = sse_pkg::KIND_PAYLOAD;
            e.res.payload_byte = b;
            e.ev.len         = ev.len + 1'b1;
            e.ok             = 1'b1;
            if (!ev.mismatch && ev.match_pos < 3'd6 && b == sse_pkg::f_done_char(ev.match_pos))
            begin
                e.ev.match_pos = ev.match_pos + 3'd1;
            end else begin
                e.ev.mismatch = 1'b1;
            end
        end
        return e;
    endfunction

    assign lim       = (CW'(r_limit) < CAP) ? CW'(r_limit) : CAP;
    assign line_full = CW'(r_line_len) >= lim;

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_cr       = r_cr;
        n_first    = r_first;
        n_ev       = r_ev;
        n_line_len = r_line_len;
        res0       = '0;
        res1       = '0;
        cnt        = 2'd0;
        e1         = '0;
        e2         = '0;
        go_on      = 1'b1;
        if (i_accept) begin
            case (i_opcode)
                sse_pkg::OP_CLEAR: begin
                    n_phase    = PH_START;
                    n_pos      = '0;
                    n_cr       = 1'b0;
                    n_first    = 1'b0;
                    n_ev       = '0;
                    n_line_len = '0;
                end
                sse_pkg::OP_QUERY: begin
                    res0.kind          = sse_pkg::KIND_COUNT;
                    res0.pending_count = 16'(r_line_len);
                    cnt                = 2'd1;
                end
                sse_pkg::OP_BYTE: begin
                    if (line_full) begin
                        res0.kind = sse_pkg::KIND_ERROR;
                        cnt       = 2'd1;
                    end else if (i_in_byte == sse_pkg::CHAR_LF) begin
                        if (r_phase == PH_START && r_ev.has_data) begin
                            res0.kind = sse_pkg::KIND_END;
                            res0.is_done_marker = !r_ev.mismatch && r_ev.match_pos == 3'd6;
                            cnt       = 2'd1;
                            n_ev      = '0;
                        end
                        n_phase    = PH_START;
                        n_pos      = '0;
                        n_cr       = 1'b0;
                        n_first    = 1'b0;
                        n_line_len = '0;
                    end else begin
                        n_line_len = r_line_len + 1'b1;
                        case (r_phase)
                            PH_START: begin
                                if (r_cr) begin
                                    n_cr    = 1'b0;
                                    n_phase = PH_IGNORE;
                                end else if (i_in_byte == sse_pkg::CHAR_CR) begin
                                    n_cr = 1'b1;
                                end else if (i_in_byte == sse_pkg::f_data_char(3'd0)) begin
                                    n_phase = PH_PREFIX;
                                    n_pos   = 3'd1;
                                end else begin
                                    n_phase = PH_IGNORE;
                                end
                            end
                            PH_PREFIX: begin
                                if (r_pos < 3'd5 && i_in_byte == sse_pkg::f_data_char(r_pos))
                                begin
                                    n_pos = r_pos + 3'd1;
                                    if (r_pos == 3'd4) begin
                                        n_phase = PH_VALUE;
                                        n_first = 1'b1;
                                        if (r_ev.has_data) begin
                                            e1   = f_emit(r_ev, sse_pkg::CHAR_LF, lim);
                                            res0 = e1.res;
                                            cnt  = 2'd1;
                                            n_ev = e1.ev;
                                            if (!e1.ok) begin
                                                n_cr    = 1'b0;
                                                n_phase = PH_IGNORE;
                                            end else begin
                                                n_ev.has_data = 1'b1;
                                            end
                                        end else begin
                                            n_ev.has_data = 1'b1;
                                        end
                                    end
                                end else begin
                                    n_phase = PH_IGNORE;
                                end
                            end
                            PH_VALUE: begin
                                if (r_cr) begin
                                    n_cr = 1'b0;
                                    e1   = f_emit(r_ev, sse_pkg::CHAR_CR, lim);
                                    res0 = e1.res;
                                    cnt  = 2'd1;
                                    n_ev = e1.ev;
                                    if (!e1.ok) begin
                                        n_phase = PH_IGNORE;
                                        go_on   = 1'b0;
                                    end
                                end
                                if (go_on) begin
                                    n_first = 1'b0;
                                    if (i_in_byte == sse_pkg::CHAR_CR) begin
                                        n_cr = 1'b1;
                                    end else if (!(r_first && i_in_byte == sse_pkg::CHAR_SPACE))
                                    begin
                                        e2 = f_emit(n_ev, i_in_byte, lim);
                                        if (cnt == 2'd0) begin
                                            res0 = e2.res;
                                        end else begin
                                            res1 = e2.res;
                                        end
                                        cnt  = cnt + 2'd1;
                                        n_ev = e2.ev;
                                        if (!e2.ok) begin
                                            n_cr    = 1'b0;
                                            n_phase = PH_IGNORE;
                                        end
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
        if (cnt == 2'd2) begin
            res1.last_of_run = 1'b1;
        end else if (cnt == 2'd1) begin
            res0.last_of_run = 1'b1;
        end
    end

    assign o_push_cnt = cnt;
    assign o_res0     = res0;
    assign o_res1     = res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= sse_pkg::SIZE_LIMIT_RESET;
            r_phase    <= PH_START;
            r_pos      <= '0;
            r_cr       <= 1'b0;
            r_first    <= 1'b0;
            r_ev       <= '0;
            r_line_len <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_cr       <= n_cr;
            r_first    <= n_first;
            r_ev       <= n_ev;
            r_line_len <= n_line_len;
        end
    end

endmodule

FILE: rtl/sse_rq.sv
// small result queue taking up to two results a cycle and giving one
`timescale 1ns / 1ps
module sse_rq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_push_cnt,
    input  sse_pkg::t_res i_res0,
    input  sse_pkg::t_res i_res1,
    input  logic          i_pop,
    output sse_pkg::t_res o_head,
    output logic          o_valid,
    output logic          o_room2
);

    localparam int AW = $clog2(sse_pkg::RQ_DEPTH);

    sse_pkg::t_res r_mem [sse_pkg::RQ_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          pop;

    assign o_valid = r_cnt != '0;
    assign o_room2 = r_cnt <= (AW+1)'(sse_pkg::RQ_DEPTH - 2);
    assign o_head  = r_mem[r_rp];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wp + AW'(1)] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + AW'(i_push_cnt);
            r_rp  <= r_rp + AW'(pop);
            r_cnt <= r_cnt + (AW+1)'(i_push_cnt) - (AW+1)'(pop);
        end
    end

endmodule

FILE: rtl/sse_event_stream_parser.sv
// top level of the server-sent-events stream parser
`timescale 1ns / 1ps
// Takes one input word per clock while input ready is high: a stream byte, a
// clear, or a pending-count query. Each accepted word is parsed in the cycle
// it is accepted and its results (none, one or two) are written into a
// four-entry result queue that drives the output channel, so results appear
// in the cycle after the word at the earliest and one result leaves per cycle
// while the output is ready. Input ready is high while the queue has room for
// two results; a byte that flushes a held CR before its own data gives two
// results. The size limit register may only be written while the parser is idle.
module sse_event_stream_parser #(
    parameter int LENGTH_BITS = sse_pkg::LENGTH_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    sse_in_if.sink      i_in,
    sse_out_if.source   o_out
);

    logic          accept;
    logic [1:0]    push_cnt;
    sse_pkg::t_res res0, res1, head;
    logic          room2;
    logic          out_valid;

    assign i_in.ready = room2;
    assign accept     = i_in.valid && room2;

    sse_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_accept   (accept),
        .i_opcode   (i_in.opcode),
        .i_in_byte  (i_in.in_byte),
        .o_push_cnt (push_cnt),
        .o_res0     (res0),
        .o_res1     (res1)
    );

    sse_rq u_rq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_cnt(push_cnt),
        .i_res0    (res0),
        .i_res1    (res1),
        .i_pop     (o_out.ready),
        .o_head    (head),
        .o_valid   (out_valid),
        .o_room2   (room2)
    );

    assign o_out.valid          = out_valid;
    assign o_out.kind           = head.kind;
    assign o_out.payload_byte   = head.payload_byte;
    assign o_out.is_done_marker = head.is_done_marker;
    assign o_out.pending_count  = head.pending_count;
    assign o_out.last_of_run    = head.last_of_run;

endmodule

FILE: dv/tb_top.sv
// self-checking bench for the server-sent-events parser: random streams against a parser model
`timescale 1ns / 1ps
module tb_top;

    localparam logic [1:0]  OP_SPARE = 2'd3;
    localparam logic [7:0]  CHAR_COLON = 8'h3a;
    localparam logic [39:0] DATA_TAG = "data:";
    localparam logic [47:0] DONE_TAG = "[DONE]";

    typedef enum logic [1:0] {LN_START, LN_PREFIX, LN_VALUE, LN_SKIP} t_line_phase;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] in_byte;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    sse_in_if  in_if ();
    sse_out_if out_if ();

    sse_event_stream_parser uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #2 i_clk = ~i_clk;

    // parser model state
    t_line_phase ln_phase;
    logic [2:0]  prefix_idx;
    logic        cr_pending;
    logic        at_value_start;
    logic        evt_open;
    logic [15:0] line_len;
    logic [15:0] evt_len;
    logic [2:0]  done_idx;
    logic        done_broken;
    logic [15:0] size_cap;

    sse_pkg::t_res step_results[$];
    sse_pkg::t_res expected_results[$];
    t_word         pending_words[$];

    int fault_count = 0;
    int stim_count = 0;
    int words_taken = 0;
    int kind_seen[4] = '{0, 0, 0, 0};
    int done_seen = 0;
    int in_gap = 0;
    int out_stall = 0;
    bit in_steady = 1'b0;
    bit out_steady = 1'b0;

    int unsigned plan_limit[7]  = '{65535, 1, 0, 6, 13, 40, 4096};
    int          plan_budget[7] = '{250, 40, 30, 120, 200, 230, 230};

    function automatic void clear_event();
        evt_open = 1'b0;
        evt_len = '0;
        done_idx = '0;
        done_broken = 1'b0;
    endfunction

    function automatic void clear_line();
        ln_phase = LN_START;
        prefix_idx = '0;
        cr_pending = 1'b0;
        at_value_start = 1'b0;
        line_len = '0;
    endfunction

    function automatic void add_result(logic [1:0] kind, logic [7:0] b, logic done,
                                       logic [15:0] count);
        sse_pkg::t_res r;
        r.kind = kind;
        r.payload_byte = b;
        r.is_done_marker = done;
        r.pending_count = count;
        r.last_of_run = 1'b0;
        step_results = {step_results, r};
    endfunction

    // one byte of event data, or a size error that drops the event
    function automatic bit send_data(logic [7:0] b);
        if (int'(evt_len) + 1 > int'(size_cap)) begin
            add_result(sse_pkg::KIND_ERROR, 8'h00, 1'b0, 16'h0000);
            clear_event();
            cr_pending = 1'b0;
            ln_phase = LN_SKIP;
            return 1'b0;
        end
        add_result(sse_pkg::KIND_PAYLOAD, b, 1'b0, 16'h0000);
        evt_len = evt_len + 16'd1;
        if (!done_broken && done_idx < 3'd6 && b == DONE_TAG[8 * (5 - int'(done_idx)) +: 8])
            done_idx = done_idx + 3'd1;
        else
            done_broken = 1'b1;
        return 1'b1;
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        bit ok;
        if (int'(line_len) + 1 > int'(size_cap)) begin
            add_result(sse_pkg::KIND_ERROR, 8'h00, 1'b0, 16'h0000);
            return;
        end
        if (b == sse_pkg::CHAR_LF) begin
            if (ln_phase == LN_START && evt_open) begin
                add_result(sse_pkg::KIND_END, 8'h00, !done_broken && done_idx == 3'd6,
                           16'h0000);
                clear_event();
            end
            clear_line();
            return;
        end
        line_len = line_len + 16'd1;
        case (ln_phase)
            LN_START: begin
                if (cr_pending) begin
                    cr_pending = 1'b0;
                    ln_phase = LN_SKIP;
                end else if (b == sse_pkg::CHAR_CR) begin
                    cr_pending = 1'b1;
                end else if (b == DATA_TAG[39:32]) begin
                    ln_phase = LN_PREFIX;
                    prefix_idx = 3'd1;
                end else begin
                    ln_phase = LN_SKIP;
                end
            end
            LN_PREFIX: begin
                if (prefix_idx < 3'd5 && b == DATA_TAG[8 * (4 - int'(prefix_idx)) +: 8]) begin
                    prefix_idx = prefix_idx + 3'd1;
                    if (prefix_idx == 3'd5) begin
                        ln_phase = LN_VALUE;
                        at_value_start = 1'b1;
                        ok = 1'b1;
                        if (evt_open)
                            ok = send_data(sse_pkg::CHAR_LF);
                        if (ok)
                            evt_open = 1'b1;
                    end
                end else begin
                    ln_phase = LN_SKIP;
                end
            end
            LN_VALUE: begin
                ok = 1'b1;
                if (cr_pending) begin
                    cr_pending = 1'b0;
                    ok = send_data(sse_pkg::CHAR_CR);
                end
                if (ok) begin
                    if (b == sse_pkg::CHAR_CR) begin
                        cr_pending = 1'b1;
                        at_value_start = 1'b0;
                    end else if (at_value_start && b == sse_pkg::CHAR_SPACE) begin
                        at_value_start = 1'b0;
                    end else begin
                        at_value_start = 1'b0;
                        void'(send_data(b));
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void predict_word(logic [1:0] op, logic [7:0] b);
        sse_pkg::t_res r;
        step_results.delete();
        case (op)
            sse_pkg::OP_BYTE:  parse_byte(b);
            sse_pkg::OP_CLEAR: begin
                clear_line();
                clear_event();
            end
            sse_pkg::OP_QUERY: add_result(sse_pkg::KIND_COUNT, 8'h00, 1'b0, line_len);
            default: begin
            end
        endcase
        foreach (step_results[i]) begin
            r = step_results[i];
            r.last_of_run = (i == step_results.size() - 1);
            expected_results = {expected_results, r};
        end
    endfunction

    function automatic int draw_wait(bit steady);
        return steady ? 0 : $urandom_range(0, 10);
    endfunction

    // input driver
    always @(posedge i_clk) begin : drv
        t_word w;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_gap <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid) begin
                predict_word(in_if.opcode, in_if.in_byte);
                words_taken++;
            end
            if (in_gap != 0) begin
                in_gap <= in_gap - 1;
                in_if.valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                w = pending_words.pop_front();
                in_if.valid <= 1'b1;
                in_if.opcode <= w.opcode;
                in_if.in_byte <= w.in_byte;
                if ($urandom_range(0, 39) == 0)
                    in_steady = !in_steady;
                in_gap <= draw_wait(in_steady);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fault_count++;
        end
    endtask

    task automatic check_result();
        sse_pkg::t_res want;
        if (expected_results.size() == 0) begin
            $error("unexpected result: kind %0d byte %0h", out_if.kind, out_if.payload_byte);
            fault_count++;
        end else begin
            want = expected_results.pop_front();
            compare_field("kind", 16'(want.kind), 16'(out_if.kind));
            compare_field("payload_byte", 16'(want.payload_byte), 16'(out_if.payload_byte));
            compare_field("is_done_marker", 16'(want.is_done_marker),
                          16'(out_if.is_done_marker));
            compare_field("pending_count", want.pending_count, out_if.pending_count);
            compare_field("last_of_run", 16'(want.last_of_run), 16'(out_if.last_of_run));
        end
        kind_seen[out_if.kind]++;
        if (out_if.kind == sse_pkg::KIND_END && out_if.is_done_marker)
            done_seen++;
    endtask

    // result monitor with random back-pressure
    always @(posedge i_clk) begin : mon
        int s;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            out_stall <= 0;
        end else if (out_if.valid && out_if.ready) begin
            check_result();
            if ($urandom_range(0, 39) == 0)
                out_steady = !out_steady;
            s = draw_wait(out_steady);
            out_stall <= s;
            out_if.ready <= (s == 0);
        end else if (out_stall != 0) begin
            out_stall <= out_stall - 1;
            out_if.ready <= (out_stall == 1);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    task automatic push_word(logic [1:0] op, logic [7:0] b);
        t_word w;
        w.opcode = op;
        w.in_byte = b;
        pending_words = {pending_words, w};
        if (op != OP_SPARE)
            stim_count++;
    endtask

    task automatic push_text(string s);
        foreach (s[i])
            push_word(sse_pkg::OP_BYTE, s[i]);
    endtask

    task automatic push_line_end();
        if ($urandom_range(0, 2) == 0)
            push_text("\r\n");
        else
            push_text("\n");
    endtask

    function automatic logic [7:0] value_char();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0:       return sse_pkg::CHAR_CR;
            1:       return sse_pkg::CHAR_SPACE;
            2:       return CHAR_COLON;
            3:       return 8'($urandom_range(0, 255));
            4, 5:    return DONE_TAG[8 * $urandom_range(0, 5) +: 8];
            default: return 8'($urandom_range(33, 126));
        endcase
    endfunction

    task automatic push_data_line();
        int n;
        push_text("data:");
        if ($urandom_range(0, 1) != 0)
            push_word(sse_pkg::OP_BYTE, sse_pkg::CHAR_SPACE);
        if ($urandom_range(0, 5) == 0) begin
            push_text("[DONE]");
        end else begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
            repeat (n) begin
                if ($urandom_range(0, 39) == 0)
                    push_word(sse_pkg::OP_QUERY, 8'($urandom_range(0, 255)));
                push_word(sse_pkg::OP_BYTE, value_char());
            end
        end
        push_line_end();
    endtask

    task automatic push_noise_line();
        case ($urandom_range(0, 5))
            0: push_text(": keep-alive");
            1: push_text("event: update");
            2: push_text("id: 42");
            3: push_text("dat");
            4: push_text("data");
            default: push_text("\rdata:x");
        endcase
        if ($urandom_range(0, 1) != 0)
            push_word(sse_pkg::OP_BYTE, value_char());
        push_line_end();
    endtask

    task automatic push_event();
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 5) == 0)
                push_noise_line();
            else
                push_data_line();
        end
        if ($urandom_range(0, 9) != 0)
            push_line_end();
    endtask

    task automatic gen_stream(int budget);
        int start;
        int r;
        start = stim_count;
        while (stim_count - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                push_event();
            end else if (r < 85) begin
                push_noise_line();
            end else if (r < 95) begin
                repeat ($urandom_range(1, 6))
                    push_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end else begin
                push_word($urandom_range(0, 1) ? sse_pkg::OP_QUERY : sse_pkg::OP_CLEAR,
                          8'($urandom_range(0, 255)));
            end
        end
    endtask

    // lets the parser run dry before the size limit is touched
    task automatic wait_idle();
        while (pending_words.size() != 0 || in_if.valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_size_limit(logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        size_cap = v;
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        in_if.valid = 1'b0;
        in_if.opcode = sse_pkg::OP_BYTE;
        in_if.in_byte = 8'h00;
        out_if.ready = 1'b0;
        clear_line();
        clear_event();
        size_cap = sse_pkg::SIZE_LIMIT_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_word(sse_pkg::OP_QUERY, 8'h00);
        push_text("data: [DONE]\r\n");
        push_text("\n");
        push_text(":c\n");
        push_word(sse_pkg::OP_BYTE, 8'hff);
        push_word(sse_pkg::OP_QUERY, 8'hff);
        push_word(sse_pkg::OP_CLEAR, 8'h00);
        push_word(OP_SPARE, 8'h00);
        push_word(sse_pkg::OP_BYTE, 8'h00);
        push_word(sse_pkg::OP_QUERY, 8'h00);
        wait_idle();

        foreach (plan_limit[i]) begin
            write_size_limit(16'(plan_limit[i]));
            gen_stream(plan_budget[i]);
            wait_idle();
        end

        $display("run covered %0d input words over %0d size limit settings, incl. zero and full range",
                 words_taken, $size(plan_limit) + 1);
        $display("results: %0d payload, %0d event ends (%0d done), %0d size errors, %0d counts",
                 kind_seen[sse_pkg::KIND_PAYLOAD], kind_seen[sse_pkg::KIND_END], done_seen,
                 kind_seen[sse_pkg::KIND_ERROR], kind_seen[sse_pkg::KIND_COUNT]);
        if (fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
